### hdl/pbfm_pkg.sv
// Package with sizes, hash constants and item types of the partitioned Bloom filter.
`default_nettype none
package pbfm_pkg;

    localparam int unsigned TOTAL_BITS    = 16384;
    localparam int unsigned NUM_HASHES    = 4;
    localparam int unsigned MAX_KEY_BYTES = 1024;

    localparam int unsigned SEG_BITS  = TOTAL_BITS / NUM_HASHES;
    localparam int unsigned SEG_SH    = $clog2(SEG_BITS);
    localparam int unsigned ADDR_W    = $clog2(TOTAL_BITS);
    localparam int unsigned IDX_W     = (NUM_HASHES > 1) ? $clog2(NUM_HASHES) : 1;
    localparam int unsigned KEY_LEN_W = $clog2(MAX_KEY_BYTES + 1);

    localparam logic [31:0] MIX_M   = 32'h5bd1e995;
    localparam int unsigned BLK_SH  = 24;
    localparam int unsigned FIN_SH1 = 13;
    localparam int unsigned FIN_SH2 = 15;

    // Rounded-up reciprocal of the segment size, exact for every 32-bit hash.
    localparam logic [64:0] RECIP_NUM = 65'd1 << (32 + SEG_SH);
    localparam logic [32:0] SEG_RECIP =
        33'((RECIP_NUM + 65'(SEG_BITS) - 65'd1) / 65'(SEG_BITS));

    localparam logic [2:0] CHUNK_FULL = 3'd4;
    localparam logic [2:0] CHUNK_NONE = 3'd0;

    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_QUERY  = 1'b1;

    typedef struct packed {
        logic                 kind;
        logic [31:0]          chunk;
        logic [2:0]           chunk_bytes;
        logic [KEY_LEN_W-1:0] key_length;
        logic                 first_chunk;
        logic                 last_chunk;
    } t_item;

    typedef struct packed {
        logic was_query;
        logic present;
    } t_result;

    typedef struct packed {
        logic              vld;
        logic              query;
        logic              first;
        logic              last;
        logic [ADDR_W-1:0] addr;
    } t_bit_req;

endpackage
`default_nettype wire

### hdl/pbfm_filter_store.sv
// Filter bit memory with its clearing pass after reset.
`default_nettype none
module pbfm_filter_store (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  pbfm_pkg::t_bit_req   i_req,
    output logic                 o_rdata,
    output logic                 o_ready
);

    logic                          mem [pbfm_pkg::TOTAL_BITS];
    logic                          r_clearing;
    logic [pbfm_pkg::ADDR_W-1:0]   r_clr_addr;
    logic                          r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == pbfm_pkg::ADDR_W'(pbfm_pkg::TOTAL_BITS - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 1'b0;
        end else if (i_req.vld && (i_req.query == pbfm_pkg::KIND_INSERT)) begin
            mem[i_req.addr] <= 1'b1;
        end
        if (i_req.vld) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_ready = !r_clearing;

endmodule
`default_nettype wire

### hdl/pbfm_hasher.sv
// Running hash store, shared multiplier and sequencer that mixes, finalizes and addresses.
`default_nettype none
module pbfm_hasher (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_start,
    input  pbfm_pkg::t_item      i_item,
    output logic                 o_busy,
    output pbfm_pkg::t_bit_req   o_req
);

    typedef enum logic [3:0] {
        S_IDLE, S_BLK1, S_BLK2, S_BLK3, S_RD, S_MIX, S_MIX2, S_WB,
        S_FIN1, S_FIN2, S_FIN3, S_FIN4
    } t_state;

    localparam logic [pbfm_pkg::IDX_W-1:0] LAST_IDX =
        pbfm_pkg::IDX_W'(pbfm_pkg::NUM_HASHES - 1);

    t_state                              r_state;
    logic                                r_kind;
    logic [31:0]                         r_word;
    logic [2:0]                          r_nb;
    logic [pbfm_pkg::KEY_LEN_W-1:0]      r_klen;
    logic                                r_first;
    logic                                r_last;
    logic [31:0]                         r_blk;
    logic [31:0]                         r_h;
    logic [31:0]                         r_hrd;
    logic [pbfm_pkg::IDX_W-1:0]          r_idx;
    logic [pbfm_pkg::ADDR_W-1:0]         r_base;
    logic [64:0]                         r_prod;
    pbfm_pkg::t_bit_req                  r_req;

    logic [31:0] hmem [pbfm_pkg::NUM_HASHES];

    logic [31:0]                  mul_a;
    logic [32:0]                  mul_b;
    logic [64:0]                  prod;
    logic [31:0]                  p_lo;
    logic [31:0]                  h0;
    logic [31:0]                  tail;
    logic [2:0]                   sat_nb;
    logic [pbfm_pkg::ADDR_W-1:0]  pos;

    function automatic logic [31:0] tail_of(logic [31:0] w, logic [2:0] nb);
        logic [31:0] t;
        case (nb)
            3'd1:    t = {24'h0, w[7:0]};
            3'd2:    t = {16'h0, w[15:0]};
            3'd3:    t = {8'h0, w[23:0]};
            default: t = 32'h0;
        endcase
        return t;
    endfunction

    assign sat_nb = (i_item.chunk_bytes > pbfm_pkg::CHUNK_FULL) ?
                    pbfm_pkg::CHUNK_FULL : i_item.chunk_bytes;
    assign p_lo   = r_prod[31:0];
    assign tail   = tail_of(r_word, r_nb);
    assign h0     = r_first ? ((32'(r_idx) + 32'd1) ^ 32'(r_klen)) : r_hrd;
    assign pos    = pbfm_pkg::ADDR_W'(r_h - p_lo);
    assign prod   = {33'h0, mul_a} * {32'h0, mul_b};

    always_comb begin
        mul_a = 32'h0;
        mul_b = {1'b0, pbfm_pkg::MIX_M};
        unique case (r_state)
            S_BLK1: mul_a = r_word;
            S_BLK2: mul_a = p_lo ^ (p_lo >> pbfm_pkg::BLK_SH);
            S_MIX:  mul_a = (r_nb == pbfm_pkg::CHUNK_FULL) ? h0 : (h0 ^ tail);
            S_FIN1: mul_a = r_h ^ (r_h >> pbfm_pkg::FIN_SH1);
            S_FIN2: begin
                mul_a = p_lo ^ (p_lo >> pbfm_pkg::FIN_SH2);
                mul_b = pbfm_pkg::SEG_RECIP;
            end
            S_FIN3: begin
                mul_a = 32'(r_prod >> (32 + pbfm_pkg::SEG_SH));
                mul_b = 33'(pbfm_pkg::SEG_BITS);
            end
            default: mul_a = 32'h0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_RD) begin
            r_hrd <= hmem[r_idx];
        end
        if (r_state == S_WB) begin
            hmem[r_idx] <= r_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_req   <= '0;
        end else begin
            r_req.vld <= 1'b0;
            r_prod    <= prod;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_kind  <= i_item.kind;
                        r_word  <= i_item.chunk;
                        r_nb    <= sat_nb;
                        r_klen  <= i_item.key_length;
                        r_first <= i_item.first_chunk;
                        r_last  <= i_item.last_chunk;
                        r_idx   <= '0;
                        r_base  <= '0;
                        r_state <= (sat_nb == pbfm_pkg::CHUNK_FULL) ? S_BLK1 : S_RD;
                    end
                end
                S_BLK1: r_state <= S_BLK2;
                S_BLK2: r_state <= S_BLK3;
                S_BLK3: begin
                    r_blk   <= p_lo;
                    r_state <= S_RD;
                end
                S_RD: r_state <= S_MIX;
                S_MIX: begin
                    if (r_nb == pbfm_pkg::CHUNK_NONE) begin
                        r_h     <= h0;
                        r_state <= S_WB;
                    end else begin
                        r_state <= S_MIX2;
                    end
                end
                S_MIX2: begin
                    r_h     <= (r_nb == pbfm_pkg::CHUNK_FULL) ? (p_lo ^ r_blk) : p_lo;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (r_last) begin
                        r_state <= S_FIN1;
                    end else if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_state <= S_RD;
                    end
                end
                S_FIN1: r_state <= S_FIN2;
                S_FIN2: begin
                    r_h     <= p_lo ^ (p_lo >> pbfm_pkg::FIN_SH2);
                    r_state <= S_FIN3;
                end
                S_FIN3: r_state <= S_FIN4;
                S_FIN4: begin
                    r_req.vld   <= 1'b1;
                    r_req.query <= r_kind;
                    r_req.first <= (r_idx == '0);
                    r_req.last  <= (r_idx == LAST_IDX);
                    r_req.addr  <= r_base + pos;
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_idx   <= r_idx + 1'b1;
                        r_base  <= r_base + pbfm_pkg::ADDR_W'(pbfm_pkg::SEG_BITS);
                        r_state <= S_RD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy = (r_state != S_IDLE) || r_req.vld;
    assign o_req  = r_req;

endmodule
`default_nettype wire

### hdl/partitioned_bloom_filter_murmur2_unit.sv
// Top level of the partitioned Bloom filter with MurmurHash2 addressing.
// Usage: after reset the filter memory is cleared one bit per cycle, so busy stays high until
// all TOTAL_BITS bits (16384 here) are clear; only then is the first item taken. An item is a key chunk,
// taken when start is high and busy is low; busy then stays high while the chunk is worked
// on by a single shared 32x33-bit multiplier and a single-port running-hash memory, one hash
// index after another. A chunk keeps busy high while it is mixed into each running hash; a
// chunk of four bytes first adds a block step, and one with no bytes skips the second multiply.
// A last chunk also finalizes each hash and touches the filter memory. Its result is shown
// on o_result for one cycle with o_strobe high, in the first cycle in which busy is low again;
// the receiver cannot hold it off and must take it then.
`default_nettype none
module partitioned_bloom_filter_murmur2_unit (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  pbfm_pkg::t_item      i_item,
    output logic                 o_strobe,
    output pbfm_pkg::t_result    o_result
);

    logic                 store_ready;
    logic                 store_rdata;
    logic                 hash_busy;
    pbfm_pkg::t_bit_req   req;

    logic                 r_pend;
    logic                 r_rd_first;
    logic                 r_rd_last;
    logic                 r_rd_query;
    logic                 r_hit;
    logic                 r_strobe;
    pbfm_pkg::t_result    r_result;
    logic                 hit_now;

    pbfm_filter_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (store_rdata),
        .o_ready (store_ready)
    );

    pbfm_hasher u_hasher (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start && !busy),
        .i_item  (i_item),
        .o_busy  (hash_busy),
        .o_req   (req)
    );

    assign hit_now = (r_rd_first || r_hit) && store_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_pend   <= req.vld;
            r_strobe <= r_pend && r_rd_last;
            if (req.vld) begin
                r_rd_first <= req.first;
                r_rd_last  <= req.last;
                r_rd_query <= req.query;
            end
            if (r_pend) begin
                r_hit              <= hit_now;
                r_result.was_query <= r_rd_query;
                r_result.present   <= (r_rd_query == pbfm_pkg::KIND_QUERY) && hit_now;
            end
        end
    end

    assign busy     = !store_ready || hash_busy || r_pend;
    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule
`default_nettype wire
